// ----- hdl/pulse_wave_peak_valley_detector_unit_defines.svh -----
// ----------------------------------------------------------------------------
// pulse wave detector assertion macros
// shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef PULSE_WAVE_PEAK_VALLEY_DETECTOR_UNIT_DEFINES_SVH
`define PULSE_WAVE_PEAK_VALLEY_DETECTOR_UNIT_DEFINES_SVH

// checked only while out of reset
`define PWPVD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PWPVD_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/pwpvd_pkg.sv -----
// ----------------------------------------------------------------------------
// pwpvd_pkg
// widths, codes and shared types of the pulse wave peak/valley detector
// ----------------------------------------------------------------------------
package pwpvd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 2;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// operation codes
	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_RUN    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FLAT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ENOUGH = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LIMIT  = 2'd3;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_SLOPE_RANGE      = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FLAT_MARK_COUNT  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FLAT_LINE_LIMIT  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_POINTS   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_PEAK_BOTTOM_MIN  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_WAVE_COUNT_LIMIT = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_LIMIT     = 3'd6;

	typedef struct packed {
		logic [15:0]        slope_range;
		logic [15:0]        flat_mark_count;
		logic [15:0]        flat_line_limit;
		logic [15:0]        trigger_points;
		logic [15:0]        peak_bottom_min;
		logic [COUNT_W-1:0] wave_count_limit;
		logic [15:0]        sample_limit;
	} cfg_t;

	typedef struct packed {
		logic                flat;
		logic [SAMPLE_W-1:0] top_value;
		logic [15:0]         top_index;
		logic [COUNT_W-1:0]  rising;
		logic [15:0]         top_plateau;
		logic [SAMPLE_W-1:0] bottom_value;
		logic [15:0]         bottom_index;
		logic [COUNT_W-1:0]  falling;
		logic [15:0]         bottom_plateau;
	} wave_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                wave_valid;
		logic [COUNT_W-1:0]  wave_number;
		wave_t               wave;
	} res_t;

endpackage

// ----- hdl/pwpvd_if.sv -----
// ----------------------------------------------------------------------------
// pwpvd channel interfaces
// sample item, result item and register write channels
// ----------------------------------------------------------------------------
interface pwpvd_item_if;
	logic                              valid;
	logic                              ready;
	logic                              operation;
	logic [pwpvd_pkg::SAMPLE_W-1:0]    sample;

	modport source (output valid, output operation, output sample, input ready);
	modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface pwpvd_result_if;
	logic                              valid;
	logic                              ready;
	logic [pwpvd_pkg::STATUS_W-1:0]    status;
	logic                              wave_valid;
	logic [pwpvd_pkg::COUNT_W-1:0]     wave_number;
	logic                              wave_flat;
	logic [pwpvd_pkg::SAMPLE_W-1:0]    top_value;
	logic [15:0]                       top_index;
	logic [pwpvd_pkg::SAMPLE_W-1:0]    bottom_value;
	logic [15:0]                       bottom_index;
	logic [pwpvd_pkg::COUNT_W-1:0]     rising_samples;
	logic [pwpvd_pkg::COUNT_W-1:0]     falling_samples;
	logic [15:0]                       top_plateau;
	logic [15:0]                       bottom_plateau;

	modport source (
		output valid, output status, output wave_valid, output wave_number,
		output wave_flat, output top_value, output top_index, output bottom_value,
		output bottom_index, output rising_samples, output falling_samples,
		output top_plateau, output bottom_plateau, input ready
	);
	modport sink (
		input valid, input status, input wave_valid, input wave_number,
		input wave_flat, input top_value, input top_index, input bottom_value,
		input bottom_index, input rising_samples, input falling_samples,
		input top_plateau, input bottom_plateau, output ready
	);
endinterface

interface pwpvd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pwpvd_pkg::CFG_ADDR_W-1:0]   addr;
	logic [pwpvd_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- hdl/pwpvd_core.sv -----
// ----------------------------------------------------------------------------
// pwpvd_core
// slope tracking, turn confirmation and wave assembly, one sample per step
// ----------------------------------------------------------------------------
module pwpvd_core #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic                               restart,
	input  logic [pwpvd_pkg::SAMPLE_W-1:0]     sample,
	input  pwpvd_pkg::cfg_t                    cfg,
	output pwpvd_pkg::res_t                    res
);

	localparam int CW = pwpvd_pkg::COUNT_W;

	logic [SAMPLE_BITS-1:0] prev_q, prev_d;
	logic [15:0]            cnt_q, cnt_d;
	logic [15:0]            frun_q, frun_d;
	logic                   lfall_q, lfall_d;
	logic                   trend_q, trend_d;
	logic [CW-1:0]          rise_q, rise_d;
	logic [CW-1:0]          fall_q, fall_d;
	logic                   turn_q, turn_d;
	logic [pwpvd_pkg::SAMPLE_W-1:0] ctop_val_q, ctop_val_d;
	logic [15:0]            ctop_idx_q, ctop_idx_d;
	logic [pwpvd_pkg::SAMPLE_W-1:0] cbot_val_q, cbot_val_d;
	logic [15:0]            cbot_idx_q, cbot_idx_d;
	logic [15:0]            ptop_q, ptop_d;
	logic [15:0]            pbot_q, pbot_d;
	pwpvd_pkg::wave_t       pend_q, pend_d;
	logic [CW-1:0]          wcnt_q, wcnt_d;

	logic [SAMPLE_BITS-1:0] s_w;
	logic                   going_up;
	logic [SAMPLE_BITS-1:0] mag;
	logic                   flat;
	logic [15:0]            spacing;

	assign s_w      = sample[SAMPLE_BITS-1:0];
	assign going_up = s_w > prev_q;
	assign mag      = going_up ? (s_w - prev_q) : (prev_q - s_w);
	assign flat     = 16'(mag) < cfg.slope_range;
	// top index is never touched on a rising step, so the stored one serves
	assign spacing  = cbot_idx_q - pend_q.top_index;

	always_comb begin
		prev_d     = prev_q;
		cnt_d      = cnt_q;
		frun_d     = frun_q;
		lfall_d    = lfall_q;
		trend_d    = trend_q;
		rise_d     = rise_q;
		fall_d     = fall_q;
		turn_d     = turn_q;
		ctop_val_d = ctop_val_q;
		ctop_idx_d = ctop_idx_q;
		cbot_val_d = cbot_val_q;
		cbot_idx_d = cbot_idx_q;
		ptop_d     = ptop_q;
		pbot_d     = pbot_q;
		pend_d     = pend_q;
		wcnt_d     = wcnt_q;
		res        = '0;

		if (restart) begin
			prev_d  = '0;
			cnt_d   = '0;
			frun_d  = '0;
			trend_d = 1'b1;
			rise_d  = '0;
			fall_d  = '0;
			turn_d  = 1'b0;
			ptop_d  = '0;
			pbot_d  = '0;
			wcnt_d  = '0;
		end else begin
			if (flat) begin
				frun_d = (frun_q == 16'hFFFF) ? frun_q : frun_q + 16'd1;
				// a flat sample also counts toward the side it sits on
				if (lfall_q) begin
					pbot_d = pbot_q + 16'd1;
					fall_d = fall_q + 1'b1;
				end else begin
					rise_d = rise_q + 1'b1;
					ptop_d = ptop_q + 16'd1;
				end
				if (frun_d > cfg.flat_mark_count) begin
					pend_d.flat = 1'b1;
					if (frun_d > cfg.flat_line_limit)
						res.status = pwpvd_pkg::ST_FLAT;
				end
			end else begin
				lfall_d = ~going_up;
				frun_d  = '0;
			end

			if (lfall_d) begin
				if (!trend_q) begin
					if (fall_d == '0) begin
						ctop_val_d = (cnt_q != '0) ? 16'(prev_q) : 16'(s_w);
						ctop_idx_d = (cnt_q != '0) ? cnt_q - 16'd1 : '0;
						turn_d     = 1'b0;
					end
					if (16'(fall_d) > cfg.trigger_points && !turn_q) begin
						trend_d            = 1'b1;
						pend_d.top_value   = ctop_val_q;
						pend_d.top_index   = ctop_idx_q;
						pend_d.rising      = rise_d;
						pend_d.top_plateau = ptop_d;
						ptop_d             = '0;
						rise_d             = '0;
						turn_d             = 1'b1;
					end
				end
				fall_d = fall_d + 1'b1;
			end else begin
				if (trend_q) begin
					if (rise_d == '0) begin
						cbot_val_d = (cnt_q != '0) ? 16'(prev_q) : 16'(s_w);
						cbot_idx_d = (cnt_q != '0) ? cnt_q - 16'd1 : '0;
						turn_d     = 1'b0;
					end
					if (16'(rise_d) > cfg.trigger_points && !turn_q) begin
						trend_d               = 1'b0;
						pend_d.bottom_value   = cbot_val_q;
						pend_d.bottom_index   = cbot_idx_q;
						pend_d.falling        = fall_d;
						pend_d.bottom_plateau = pbot_d;
						if (spacing > cfg.peak_bottom_min) begin
							// zero peak keeps the pending wave for later
							if (pend_d.top_value != '0) begin
								res.wave_valid  = 1'b1;
								res.wave_number = wcnt_q;
								res.wave        = pend_d;
								wcnt_d = (wcnt_q == '1) ? wcnt_q : wcnt_q + 1'b1;
								pend_d = '0;
								if (wcnt_d > cfg.wave_count_limit)
									res.status = pwpvd_pkg::ST_ENOUGH;
							end
						end else begin
							pend_d = '0;
						end
						pbot_d = '0;
						fall_d = '0;
						turn_d = 1'b1;
					end
				end
				rise_d = rise_d + 1'b1;
			end

			prev_d = s_w;
			cnt_d  = cnt_q + 16'd1;
			if (cnt_d >= cfg.sample_limit)
				res.status = pwpvd_pkg::ST_LIMIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			cnt_q      <= '0;
			frun_q     <= '0;
			lfall_q    <= 1'b0;
			trend_q    <= 1'b1;
			rise_q     <= '0;
			fall_q     <= '0;
			turn_q     <= 1'b0;
			ctop_val_q <= '0;
			ctop_idx_q <= '0;
			cbot_val_q <= '0;
			cbot_idx_q <= '0;
			ptop_q     <= '0;
			pbot_q     <= '0;
			pend_q     <= '0;
			wcnt_q     <= '0;
		end else if (step) begin
			prev_q     <= prev_d;
			cnt_q      <= cnt_d;
			frun_q     <= frun_d;
			lfall_q    <= lfall_d;
			trend_q    <= trend_d;
			rise_q     <= rise_d;
			fall_q     <= fall_d;
			turn_q     <= turn_d;
			ctop_val_q <= ctop_val_d;
			ctop_idx_q <= ctop_idx_d;
			cbot_val_q <= cbot_val_d;
			cbot_idx_q <= cbot_idx_d;
			ptop_q     <= ptop_d;
			pbot_q     <= pbot_d;
			pend_q     <= pend_d;
			wcnt_q     <= wcnt_d;
		end
	end

endmodule

// ----- hdl/pulse_wave_peak_valley_detector_unit.sv -----
// ----------------------------------------------------------------------------
// pulse wave peak/valley detector
// Takes one pulse sample (or a restart) per clock while the result register
// is free or draining, and returns one result per item: session status and,
// when a valley confirms a wave, that wave's peak, valley, slope counts and
// plateaus. An accepted item sits in the input register while the slope/turn
// update runs, then lands in the result register once that is free or
// draining. Throughput is one item per clock under that condition, set by the
// state update in the core; the input register can take a new item while an
// older result waits. Register writes are taken at any cycle, ready held high.
// ----------------------------------------------------------------------------
`include "pulse_wave_peak_valley_detector_unit_defines.svh"

module pulse_wave_peak_valley_detector_unit #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	pwpvd_item_if.sink             item,
	pwpvd_result_if.source         result,
	pwpvd_cfg_if.sink              cfg
);

	pwpvd_pkg::cfg_t cfg_q;

	logic                            valid_s1;
	logic                            op_s1;
	logic [pwpvd_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                            adv;

	pwpvd_pkg::res_t res_c;
	pwpvd_pkg::res_t res_q;
	logic            out_valid_q;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slope_range      <= 16'd8;
			cfg_q.flat_mark_count  <= 16'd4;
			cfg_q.flat_line_limit  <= 16'd64;
			cfg_q.trigger_points   <= 16'd3;
			cfg_q.peak_bottom_min  <= 16'd10;
			cfg_q.wave_count_limit <= 8'd8;
			cfg_q.sample_limit     <= 16'd2048;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				pwpvd_pkg::REG_SLOPE_RANGE:      cfg_q.slope_range     <= cfg.data;
				pwpvd_pkg::REG_FLAT_MARK_COUNT:  cfg_q.flat_mark_count <= cfg.data;
				pwpvd_pkg::REG_FLAT_LINE_LIMIT:  cfg_q.flat_line_limit <= cfg.data;
				pwpvd_pkg::REG_TRIGGER_POINTS:   cfg_q.trigger_points  <= cfg.data;
				pwpvd_pkg::REG_PEAK_BOTTOM_MIN:  cfg_q.peak_bottom_min <= cfg.data;
				pwpvd_pkg::REG_WAVE_COUNT_LIMIT: begin
					cfg_q.wave_count_limit <= cfg.data[pwpvd_pkg::COUNT_W-1:0];
				end
				pwpvd_pkg::REG_SAMPLE_LIMIT:     cfg_q.sample_limit    <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register advances whenever the result register is free or draining
	assign adv        = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1     <= item.operation;
			sample_s1 <= item.sample;
		end
	end

	pwpvd_core #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.restart (op_s1 == pwpvd_pkg::OP_RESTART),
		.sample  (sample_s1),
		.cfg     (cfg_q),
		.res     (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_c;
	end

	assign result.valid           = out_valid_q;
	assign result.status          = res_q.status;
	assign result.wave_valid      = res_q.wave_valid;
	assign result.wave_number     = res_q.wave_number;
	assign result.wave_flat       = res_q.wave.flat;
	assign result.top_value       = res_q.wave.top_value;
	assign result.top_index       = res_q.wave.top_index;
	assign result.bottom_value    = res_q.wave.bottom_value;
	assign result.bottom_index    = res_q.wave.bottom_index;
	assign result.rising_samples  = res_q.wave.rising;
	assign result.falling_samples = res_q.wave.falling;
	assign result.top_plateau     = res_q.wave.top_plateau;
	assign result.bottom_plateau  = res_q.wave.bottom_plateau;

	// a restart transfer yields a quiet result
	`PWPVD_ASSERT(a_restart_quiet, (adv && op_s1 == pwpvd_pkg::OP_RESTART) |=> (res_q.status == pwpvd_pkg::ST_RUN && !res_q.wave_valid), "restart result not quiet")

	// an emitted wave never has a zero peak
	`PWPVD_ASSERT_ALWAYS(a_wave_top_nonzero, (out_valid_q && res_q.wave_valid) |-> (res_q.wave.top_value != '0), "wave emitted with zero peak")

	// a stalled item stays put in the input register
	`PWPVD_ASSERT(a_s1_hold, (valid_s1 && !adv) |=> (valid_s1 && $stable(sample_s1) && $stable(op_s1)), "input register lost a stalled item")

	// a result without a wave always comes with wave fields and wave number cleared
	`PWPVD_ASSERT(a_no_wave_zero, (out_valid_q && !res_q.wave_valid) |-> (res_q.wave == '0 && res_q.wave_number == '0), "idle wave fields not zero")

endmodule
